// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold on every edge outside reset
`define AST_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression must never be true outside reset
`define AST_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define AST_HOLDS(lbl, clk, rst, prop, msg)
`define AST_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// ----- rtl/core/klt_pkg.sv -----
// Shared types and constants for the key lease table.
// No dependencies; imported by all klt modules.
`timescale 1ns / 1ps
package klt_pkg;
   localparam int TableDepthDef = 16;
   localparam int TimeBitsDef   = 48;
   localparam int FieldBits     = 48;
   localparam int ModeBits      = 3;
   localparam int ReqDataBits   = 152;
   localparam int RspDataBits   = 160;
   localparam int RspUserBits   = 4;

   typedef enum logic [2:0] {
      MODE_ACQUIRE      = 3'd0,
      MODE_FIND         = 3'd1,
      MODE_REMOVE       = 3'd2,
      MODE_REMOVE_EXACT = 3'd3,
      MODE_LIST_EXPIRED = 3'd4,
      MODE_SNAPSHOT     = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      ST_ACQUIRED  = 3'd0,
      ST_ALREADY   = 3'd1,
      ST_CONFLICT  = 3'd2,
      ST_FOUND     = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_REMOVED   = 3'd5,
      ST_FULL      = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_RD, S_CHK, S_HIT, S_DONE, S_SH_RD, S_SH_WR
   } state_type;

   typedef enum logic [1:0] {
      SRC_EMPTY, SRC_RD, SRC_PEND, SRC_NEW
   } src_type;

   typedef struct packed {
      logic       latch_req;
      logic       idx_clr;
      logic       idx_inc;
      logic       rd_idx;
      logic       rd_next;
      logic       pend_load;
      logic       pend_clr;
      logic       out_load;
      src_type    out_src;
      status_type out_status;
      logic       out_last;
      logic       wr_new;
      logic       wr_shift;
      logic       cnt_dec;
   } ctl_cmd_type;

   typedef struct packed {
      logic [ModeBits-1:0] mode;
      logic                scan_end;
      logic                match;
      logic                owner_eq;
      logic                force_rm;
      logic                full;
      logic                out_free;
      logic                have_pend;
      logic                shift_end;
   } ctl_stat_type;
endpackage

// ----- rtl/core/klt_ctrl.sv -----
// Sequencer for the key lease table: scan, report, compaction.
// Depends on klt_pkg; drives klt_dpath through command/status structs.
`timescale 1ns / 1ps
module klt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_fire,
   output logic                  req_ready,
   input  klt_pkg::ctl_stat_type stat,
   output klt_pkg::ctl_cmd_type  cmd
);
   import klt_pkg::*;

   state_type state_ff, state_in;
   logic      list_mode;

   assign list_mode = stat.mode inside {MODE_LIST_EXPIRED, MODE_SNAPSHOT};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.out_src    = SRC_EMPTY;
      cmd.out_status = ST_NOT_FOUND;
      req_ready      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.latch_req = 1'b1;
               cmd.idx_clr   = 1'b1;
               cmd.pend_clr  = 1'b1;
               state_in      = S_RD;
            end
         end
         S_RD: begin
            if (stat.scan_end || stat.mode > MODE_SNAPSHOT) begin
               state_in = S_DONE;
            end else begin
               cmd.rd_idx = 1'b1;
               state_in   = S_CHK;
            end
         end
         S_CHK: begin
            if (list_mode) begin
               if (!stat.match) begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_RD;
               end else if (!stat.have_pend) begin
                  cmd.pend_load = 1'b1;
                  cmd.idx_inc   = 1'b1;
                  state_in      = S_RD;
               end else if (stat.out_free) begin
                  // previous match is now known not to be the final one
                  cmd.out_load   = 1'b1;
                  cmd.out_src    = SRC_PEND;
                  cmd.out_status = ST_FOUND;
                  cmd.pend_load  = 1'b1;
                  cmd.idx_inc    = 1'b1;
                  state_in       = S_RD;
               end
            end else if (stat.match) begin
               state_in = S_HIT;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_RD;
            end
         end
         S_HIT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = 1'b1;
               cmd.out_src  = SRC_RD;
               state_in     = S_IDLE;
               case (stat.mode)
                  MODE_ACQUIRE: begin
                     cmd.out_status = stat.owner_eq ? ST_ALREADY : ST_CONFLICT;
                  end
                  MODE_FIND: begin
                     cmd.out_status = ST_FOUND;
                  end
                  MODE_REMOVE: begin
                     if (stat.force_rm || stat.owner_eq) begin
                        cmd.out_status = ST_REMOVED;
                        state_in       = S_SH_RD;
                     end else begin
                        cmd.out_src = SRC_EMPTY;
                     end
                  end
                  MODE_REMOVE_EXACT: begin
                     cmd.out_status = ST_REMOVED;
                     state_in       = S_SH_RD;
                  end
                  default: begin
                     cmd.out_src = SRC_EMPTY;
                  end
               endcase
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = 1'b1;
               state_in     = S_IDLE;
               if (stat.mode == MODE_ACQUIRE) begin
                  if (stat.full) begin
                     cmd.out_status = ST_FULL;
                  end else begin
                     cmd.wr_new     = 1'b1;
                     cmd.out_src    = SRC_NEW;
                     cmd.out_status = ST_ACQUIRED;
                  end
               end else if (list_mode && stat.have_pend) begin
                  cmd.out_src    = SRC_PEND;
                  cmd.out_status = ST_FOUND;
               end
            end
         end
         S_SH_RD: begin
            if (stat.shift_end) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.rd_next = 1'b1;
               state_in    = S_SH_WR;
            end
         end
         S_SH_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = S_SH_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

// ----- rtl/core/klt_dpath.sv -----
// Datapath for the key lease table: lease memory, counters, output register.
// Depends on klt_pkg; controlled by klt_ctrl.
`timescale 1ns / 1ps
module klt_dpath #(
   parameter int TABLE_DEPTH = klt_pkg::TableDepthDef,
   parameter int TIME_BITS   = klt_pkg::TimeBitsDef
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [klt_pkg::ModeBits-1:0]     req_tuser,
   input  logic [klt_pkg::ReqDataBits-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [klt_pkg::RspDataBits-1:0]  rsp_tdata,
   output logic [klt_pkg::RspUserBits-1:0]  rsp_tuser,
   output logic                             rsp_tlast,
   input  klt_pkg::ctl_cmd_type             cmd,
   output klt_pkg::ctl_stat_type            stat
);
   import klt_pkg::*;

   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int SumW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
   localparam logic [TIME_BITS-1:0] TimeMax = {TIME_BITS{1'b1}};

   // lease store
   logic [7:0]           mem_key   [TABLE_DEPTH];
   logic [7:0]           mem_owner [TABLE_DEPTH];
   logic [FieldBits-1:0] mem_gen   [TABLE_DEPTH];
   logic [TIME_BITS-1:0] mem_start [TABLE_DEPTH];
   logic [TIME_BITS-1:0] mem_exp   [TABLE_DEPTH];

   logic [ModeBits-1:0]  mode_ff;
   logic [7:0]           key_ff, owner_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [31:0]          hold_ff;
   logic                 force_ff;
   logic [FieldBits-1:0] want_ff;

   logic [CW-1:0]        idx_ff, count_ff, idx_next;
   logic [FieldBits-1:0] gen_ctr_ff;

   logic [7:0]           rd_key_ff, rd_owner_ff;
   logic [FieldBits-1:0] rd_gen_ff;
   logic [TIME_BITS-1:0] rd_start_ff, rd_exp_ff;

   logic                 have_pend_ff;
   logic [7:0]           pd_key_ff, pd_owner_ff;
   logic [FieldBits-1:0] pd_gen_ff;
   logic [TIME_BITS-1:0] pd_start_ff, pd_exp_ff;

   logic                 out_valid_ff, out_last_ff, out_hit_ff;
   status_type           out_status_ff;
   logic [7:0]           out_key_ff, out_owner_ff;
   logic [FieldBits-1:0] out_gen_ff, out_start_ff, out_exp_ff;

   logic [SumW-1:0]      sum_full;
   logic [TIME_BITS-1:0] exp_new;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic                 rd_en, wr_en;
   logic [7:0]           wr_key, wr_owner;
   logic [FieldBits-1:0] wr_gen;
   logic [TIME_BITS-1:0] wr_start, wr_exp;

   assign idx_next = idx_ff + CW'(1);
   assign sum_full = SumW'(now_ff) + SumW'(hold_ff);
   assign exp_new  = (sum_full > SumW'(TimeMax)) ? TimeMax : TIME_BITS'(sum_full);

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         mode_ff  <= req_tuser;
         key_ff   <= req_tdata[7:0];
         owner_ff <= req_tdata[15:8];
         now_ff   <= TIME_BITS'(req_tdata[63:16]);
         hold_ff  <= req_tdata[95:64];
         force_ff <= req_tdata[96];
         want_ff  <= req_tdata[144:97];
      end
   end

   // counters
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         count_ff   <= '0;
         gen_ctr_ff <= '0;
      end else begin
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_next;
         end
         if (cmd.wr_new) begin
            count_ff   <= count_ff + CW'(1);
            gen_ctr_ff <= gen_ctr_ff + FieldBits'(1);
         end else if (cmd.cnt_dec) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   // memory ports: one read, one write
   assign rd_en    = cmd.rd_idx | cmd.rd_next;
   assign rd_addr  = cmd.rd_next ? idx_next[AW-1:0] : idx_ff[AW-1:0];
   assign wr_en    = cmd.wr_new | cmd.wr_shift;
   assign wr_addr  = cmd.wr_new ? count_ff[AW-1:0] : idx_ff[AW-1:0];
   assign wr_key   = cmd.wr_new ? key_ff     : rd_key_ff;
   assign wr_owner = cmd.wr_new ? owner_ff   : rd_owner_ff;
   assign wr_gen   = cmd.wr_new ? gen_ctr_ff : rd_gen_ff;
   assign wr_start = cmd.wr_new ? now_ff     : rd_start_ff;
   assign wr_exp   = cmd.wr_new ? exp_new    : rd_exp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_key[wr_addr]   <= wr_key;
         mem_owner[wr_addr] <= wr_owner;
         mem_gen[wr_addr]   <= wr_gen;
         mem_start[wr_addr] <= wr_start;
         mem_exp[wr_addr]   <= wr_exp;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff   <= mem_key[rd_addr];
         rd_owner_ff <= mem_owner[rd_addr];
         rd_gen_ff   <= mem_gen[rd_addr];
         rd_start_ff <= mem_start[rd_addr];
         rd_exp_ff   <= mem_exp[rd_addr];
      end
   end

   // held list match
   always_ff @(posedge clock) begin
      if (reset) begin
         have_pend_ff <= 1'b0;
      end else if (cmd.pend_clr) begin
         have_pend_ff <= 1'b0;
      end else if (cmd.pend_load) begin
         have_pend_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pend_load) begin
         pd_key_ff   <= rd_key_ff;
         pd_owner_ff <= rd_owner_ff;
         pd_gen_ff   <= rd_gen_ff;
         pd_start_ff <= rd_start_ff;
         pd_exp_ff   <= rd_exp_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_status_ff <= cmd.out_status;
         out_last_ff   <= cmd.out_last;
         case (cmd.out_src)
            SRC_RD: begin
               out_hit_ff   <= 1'b1;
               out_key_ff   <= rd_key_ff;
               out_owner_ff <= rd_owner_ff;
               out_gen_ff   <= rd_gen_ff;
               out_start_ff <= FieldBits'(rd_start_ff);
               out_exp_ff   <= FieldBits'(rd_exp_ff);
            end
            SRC_PEND: begin
               out_hit_ff   <= 1'b1;
               out_key_ff   <= pd_key_ff;
               out_owner_ff <= pd_owner_ff;
               out_gen_ff   <= pd_gen_ff;
               out_start_ff <= FieldBits'(pd_start_ff);
               out_exp_ff   <= FieldBits'(pd_exp_ff);
            end
            SRC_NEW: begin
               out_hit_ff   <= 1'b1;
               out_key_ff   <= key_ff;
               out_owner_ff <= owner_ff;
               out_gen_ff   <= gen_ctr_ff;
               out_start_ff <= FieldBits'(now_ff);
               out_exp_ff   <= FieldBits'(exp_new);
            end
            default: begin
               out_hit_ff   <= 1'b0;
               out_key_ff   <= '0;
               out_owner_ff <= '0;
               out_gen_ff   <= '0;
               out_start_ff <= '0;
               out_exp_ff   <= '0;
            end
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_hit_ff, out_status_ff};
   assign rsp_tdata  = {out_exp_ff, out_start_ff, out_gen_ff, out_owner_ff, out_key_ff};

   // status toward the sequencer
   always_comb begin
      stat           = '0;
      stat.mode      = mode_ff;
      stat.scan_end  = (idx_ff == count_ff);
      stat.owner_eq  = (rd_owner_ff == owner_ff);
      stat.force_rm  = force_ff;
      stat.full      = (count_ff == CW'(TABLE_DEPTH));
      stat.out_free  = !out_valid_ff || rsp_tready;
      stat.have_pend = have_pend_ff;
      stat.shift_end = (idx_next >= count_ff);
      case (mode_ff)
         MODE_ACQUIRE, MODE_FIND, MODE_REMOVE: stat.match = (rd_key_ff == key_ff);
         MODE_REMOVE_EXACT: stat.match = (rd_key_ff == key_ff) && (rd_gen_ff == want_ff);
         MODE_LIST_EXPIRED: stat.match = (rd_exp_ff <= now_ff);
         MODE_SNAPSHOT:     stat.match = 1'b1;
         default:           stat.match = 1'b0;
      endcase
   end
endmodule

// ----- rtl/core/key_lease_table.sv -----
// Key lease table: lease store kept in insertion order, one lease per key.
//
// Channels: req_* takes one operation per transaction; the opcode travels in
// req_tuser (0 acquire, 1 find, 2 remove, 3 remove_exact, 4 list_expired,
// 5 snapshot). rsp_* returns one or more result transactions per request,
// rsp_tlast marking the final one. rsp_tuser carries status and the hit flag.
// The table is walked one entry at a time, each visited by a registered
// memory read, then a compare. A removal then compacts the table with a
// read and a write per following entry. One request is worked at a time;
// req_tready is high only when the sequencer is idle. Results sit in an
// output register; when the receiver stalls, the scan pauses at the next
// result to be written and resumes when the register frees up. No result
// is lost or repeated.
// Reset (synchronous, active high) empties the table and clears the
// generation counter; no clearing pass is needed since only entries below
// the fill count are ever read.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module key_lease_table #(
   parameter int TABLE_DEPTH = klt_pkg::TableDepthDef,
   parameter int TIME_BITS   = klt_pkg::TimeBitsDef
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [2:0] mode
   input  logic [klt_pkg::ModeBits-1:0]    req_tuser,
   // [7:0] key_code, [15:8] owner_id, [63:16] now_ms, [95:64] hold_ms,
   // [96] force_req, [144:97] want_generation, [151:145] zero
   input  logic [klt_pkg::ReqDataBits-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] lease_key, [15:8] lease_owner, [63:16] lease_generation,
   // [111:64] acquired_ms, [159:112] expires_ms
   output logic [klt_pkg::RspDataBits-1:0] rsp_tdata,
   // [2:0] status, [3] hit
   output logic [klt_pkg::RspUserBits-1:0] rsp_tuser,
   output logic                            rsp_tlast
);
   import klt_pkg::*;

   ctl_cmd_type  cmd;
   ctl_stat_type stat;
   logic         req_fire;

   assign req_fire = req_tvalid & req_tready;

   klt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   klt_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TIME_BITS   (TIME_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .stat       (stat)
   );

   // checks
   `AST_NEVER(a_no_write_when_full, clock, reset, cmd.wr_new && stat.full, "insert into full table")
   `AST_HOLDS(a_one_writer, clock, reset, $onehot0({cmd.wr_new, cmd.wr_shift}), "two writers")
   `AST_HOLDS(a_load_when_free, clock, reset, cmd.out_load |-> stat.out_free, "output overrun")
   `AST_NEVER(a_idle_no_read, clock, reset, req_tready && (cmd.rd_idx || cmd.rd_next), "idle read")
endmodule

// ----- tb/tb_key_lease_table.sv -----
// Self-checking testbench for key_lease_table: directed and random lease traffic.
// Depends on klt_pkg and the key_lease_table RTL; the predictor lives in this file.
`timescale 1ns / 1ps
module tb_key_lease_table;
   import klt_pkg::*;

   localparam int Depth = 16;
   localparam logic [47:0] TimeMax = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  key;
      logic [7:0]  owner;
      logic [47:0] now;
      logic [31:0] hold;
      logic        force_rm;
      logic [47:0] want_gen;
   } lease_req_type;

   typedef struct packed {
      status_type  status;
      logic        hit;
      logic [7:0]  key;
      logic [7:0]  owner;
      logic [47:0] gen;
      logic [47:0] start;
      logic [47:0] expiry;
      logic        last;
   } lease_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ModeBits-1:0] req_tuser = '0;
   logic [ReqDataBits-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RspDataBits-1:0] rsp_tdata;
   logic [RspUserBits-1:0] rsp_tuser;
   logic rsp_tlast;

   key_lease_table u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #10 clock = ~clock;

   // shadow copy of the lease table
   int          shadow_count = 0;
   logic [7:0]  shadow_key [Depth];
   logic [7:0]  shadow_owner [Depth];
   logic [47:0] shadow_gen [Depth];
   logic [47:0] shadow_start [Depth];
   logic [47:0] shadow_expiry [Depth];
   logic [47:0] shadow_gen_ctr = '0;

   lease_req_type pending_reqs[$];
   lease_rsp_type expected_rsps[$];
   int  errors = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  recv_hold = 0;

   function automatic void queue_rsp(lease_rsp_type r);
      expected_rsps.insert(expected_rsps.size(), r);
   endfunction

   function automatic void queue_req(lease_req_type q);
      pending_reqs.insert(pending_reqs.size(), q);
   endfunction

   function automatic lease_rsp_type empty_rsp(status_type st);
      lease_rsp_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic lease_rsp_type lease_rsp(status_type st, int i, bit lst);
      lease_rsp_type r;
      r.status = st;
      r.hit = 1'b1;
      r.key = shadow_key[i];
      r.owner = shadow_owner[i];
      r.gen = shadow_gen[i];
      r.start = shadow_start[i];
      r.expiry = shadow_expiry[i];
      r.last = lst;
      return r;
   endfunction

   // Apply one operation to the shadow table and queue its results.
   task automatic predict_lease_op(lease_req_type q);
      int pos;
      int n;
      logic [48:0] sum;
      pos = -1;
      n = 0;
      for (int i = 0; i < shadow_count; i++)
         if (pos < 0 && shadow_key[i] == q.key &&
             (q.mode != MODE_REMOVE_EXACT || shadow_gen[i] == q.want_gen))
            pos = i;
      case (q.mode)
         MODE_ACQUIRE: begin
            if (pos >= 0)
               queue_rsp(lease_rsp(shadow_owner[pos] == q.owner ?
                                   ST_ALREADY : ST_CONFLICT, pos, 1));
            else if (shadow_count >= Depth)
               queue_rsp(empty_rsp(ST_FULL));
            else begin
               shadow_key[shadow_count] = q.key;
               shadow_owner[shadow_count] = q.owner;
               shadow_gen[shadow_count] = shadow_gen_ctr;
               shadow_gen_ctr = shadow_gen_ctr + 48'd1;
               shadow_start[shadow_count] = q.now;
               sum = {1'b0, q.now} + {17'b0, q.hold};
               shadow_expiry[shadow_count] = sum[48] ? TimeMax : sum[47:0];
               queue_rsp(lease_rsp(ST_ACQUIRED, shadow_count, 1));
               shadow_count++;
            end
         end
         MODE_FIND:
            queue_rsp(pos < 0 ? empty_rsp(ST_NOT_FOUND) :
                      lease_rsp(ST_FOUND, pos, 1));
         MODE_REMOVE, MODE_REMOVE_EXACT: begin
            if (pos < 0 || (q.mode == MODE_REMOVE && !q.force_rm &&
                            shadow_owner[pos] != q.owner))
               queue_rsp(empty_rsp(ST_NOT_FOUND));
            else begin
               queue_rsp(lease_rsp(ST_REMOVED, pos, 1));
               // close the gap, order kept
               for (int j = pos; j + 1 < shadow_count; j++) begin
                  shadow_key[j] = shadow_key[j+1];
                  shadow_owner[j] = shadow_owner[j+1];
                  shadow_gen[j] = shadow_gen[j+1];
                  shadow_start[j] = shadow_start[j+1];
                  shadow_expiry[j] = shadow_expiry[j+1];
               end
               shadow_count--;
            end
         end
         MODE_LIST_EXPIRED, MODE_SNAPSHOT: begin
            for (int i = 0; i < shadow_count; i++)
               if (q.mode == MODE_SNAPSHOT || shadow_expiry[i] <= q.now) begin
                  queue_rsp(lease_rsp(ST_FOUND, i, 0));
                  n++;
               end
            if (n == 0)
               queue_rsp(empty_rsp(ST_NOT_FOUND));
            else
               expected_rsps[$].last = 1'b1;
         end
         default:
            queue_rsp(empty_rsp(ST_NOT_FOUND));
      endcase
   endtask

   // Driver: one transaction offered per pending item; valid stays up across
   // back-to-back items with a single assignment per edge.
   always @(posedge clock) begin
      lease_req_type nx;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_lease_op(pending_reqs.pop_front());
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nx = pending_reqs[0];
               req_tvalid <= 1'b1;
               req_tuser <= nx.mode;
               req_tdata <= {7'b0, nx.want_gen, nx.force_rm, nx.hold, nx.now,
                             nx.owner, nx.key};
            end else
               req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor / checker for the result channel.
   always @(posedge clock) begin
      lease_rsp_type got;
      lease_rsp_type exp;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tuser[2:0]);
            got.hit = rsp_tuser[3];
            {got.expiry, got.start, got.gen, got.owner, got.key} = rsp_tdata;
            got.last = rsp_tlast;
            if (expected_rsps.size() == 0) begin
               $error("unexpected result transaction");
               errors++;
            end else begin
               exp = expected_rsps.pop_front();
               if (got.status != exp.status) begin
                  $error("status exp %0d got %0d", exp.status, got.status); errors++;
               end
               if (got.hit != exp.hit) begin
                  $error("hit exp %0d got %0d", exp.hit, got.hit); errors++;
               end
               if (got.key != exp.key) begin
                  $error("lease_key exp %0h got %0h", exp.key, got.key); errors++;
               end
               if (got.owner != exp.owner) begin
                  $error("lease_owner exp %0h got %0h", exp.owner, got.owner); errors++;
               end
               if (got.gen != exp.gen) begin
                  $error("lease_generation exp %0h got %0h", exp.gen, got.gen); errors++;
               end
               if (got.start != exp.start) begin
                  $error("acquired_ms exp %0h got %0h", exp.start, got.start); errors++;
               end
               if (got.expiry != exp.expiry) begin
                  $error("expires_ms exp %0h got %0h", exp.expiry, got.expiry); errors++;
               end
               if (got.last != exp.last) begin
                  $error("last exp %0d got %0d", exp.last, got.last); errors++;
               end
            end
         end
         rsp_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic lease_req_type mk_req(logic [2:0] m, logic [7:0] k, logic [7:0] o,
                                            logic [47:0] nw, logic [31:0] h,
                                            logic f, logic [47:0] g);
      lease_req_type q;
      q.mode = m; q.key = k; q.owner = o; q.now = nw;
      q.hold = h; q.force_rm = f; q.want_gen = g;
      return q;
   endfunction

   // Random item: small key and owner pools most of the time so hits are common.
   function automatic lease_req_type rand_req();
      lease_req_type q;
      int sel;
      sel = $urandom_range(99);
      q.mode = sel < 38 ? MODE_ACQUIRE : sel < 50 ? MODE_FIND : sel < 68 ? MODE_REMOVE :
               sel < 78 ? MODE_REMOVE_EXACT : sel < 88 ? MODE_LIST_EXPIRED :
               sel < 96 ? MODE_SNAPSHOT : 3'($urandom_range(7));
      q.key = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(20));
      q.owner = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(3));
      q.now = $urandom_range(9) == 0 ? 48'({$urandom, $urandom}) :
              48'($urandom_range(100000));
      q.hold = $urandom_range(9) == 0 ? $urandom : 32'($urandom_range(50000));
      q.force_rm = 1'($urandom_range(1));
      q.want_gen = $urandom_range(4) == 0 ? 48'({$urandom, $urandom}) :
                   (shadow_gen_ctr > 8 ? shadow_gen_ctr - 48'($urandom_range(8)) :
                    48'($urandom_range(8)));
      return q;
   endfunction

   task automatic drain_and_wait();
      wait (pending_reqs.size() == 0 && !req_tvalid && expected_rsps.size() == 0);
      repeat (80) @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // directed: empty-table cases, full table, held keys, extremes
      queue_req(mk_req(MODE_SNAPSHOT, 0, 0, 0, 0, 0, 0));
      queue_req(mk_req(MODE_LIST_EXPIRED, 0, 0, TimeMax, 0, 0, 0));
      queue_req(mk_req(MODE_FIND, 8'hFF, 0, 0, 0, 0, 0));
      queue_req(mk_req(MODE_REMOVE, 8'hFF, 8'hFF, 0, 0, 1, 0));
      for (int i = 0; i < 16; i++)
         queue_req(mk_req(MODE_ACQUIRE, 8'(i * 17), 8'(i),
                          i == 0 ? TimeMax : 48'(i * 100),
                          i == 1 ? 32'hFFFF_FFFF : 32'(i), 0, 0));
      queue_req(mk_req(MODE_ACQUIRE, 8'h77, 1, 5, 5, 0, 0));
      queue_req(mk_req(MODE_ACQUIRE, 8'h11, 1, 0, 0, 0, 0));
      queue_req(mk_req(MODE_ACQUIRE, 8'h11, 2, 0, 0, 0, 0));
      queue_req(mk_req(MODE_LIST_EXPIRED, 0, 0, 48'd800, 0, 0, 0));
      queue_req(mk_req(MODE_SNAPSHOT, 0, 0, 0, 0, 0, 0));
      queue_req(mk_req(MODE_REMOVE, 8'h22, 9, 0, 0, 0, 0));
      queue_req(mk_req(MODE_REMOVE, 8'h22, 2, 0, 0, 0, 0));
      queue_req(mk_req(MODE_REMOVE, 8'h33, 9, 0, 0, 1, 0));
      queue_req(mk_req(MODE_REMOVE_EXACT, 8'h44, 0, 0, 0, 0, 48'd7));
      queue_req(mk_req(MODE_REMOVE_EXACT, 8'h44, 0, 0, 0, 0, 48'd4));
      queue_req(mk_req(3'd6, 0, 0, 0, 0, 0, 0));
      queue_req(mk_req(3'd7, 0, 0, 0, 0, 0, 0));
      // long receiver stall: block must stall its input while items keep coming
      recv_hold = 1;
      for (int i = 0; i < 10; i++) queue_req(rand_req());
      repeat (400) @(posedge clock);
      recv_hold = 0;
      drain_and_wait();
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = ph == 0 ? 31 : ph == 1 ? 68 : 0;
         recv_idle_pct = ph == 0 ? 68 : ph == 1 ? 31 : 0;
         for (int i = 0; i < 139; i++) begin
            wait (pending_reqs.size() < 4);
            queue_req(rand_req());
            @(posedge clock);
         end
         drain_and_wait();
      end
      if (errors == 0)
         $display("key_lease_table regression: pass");
      else
         $display("key_lease_table regression: fail");
      $finish;
   end

   initial begin
      #20ms;
      $display("key_lease_table regression: fail");
      $finish;
   end
endmodule

// ----- key_lease_table.f -----
+incdir+rtl/core
rtl/core/klt_pkg.sv
rtl/core/klt_ctrl.sv
rtl/core/klt_dpath.sv
rtl/core/key_lease_table.sv
tb/tb_key_lease_table.sv
